@@ rtl/nmtc_pkg.sv @@
// Shared constants, types and helper functions for the mode truncation block.
package nmtc_pkg;

   // Default limits, overridable at the top level
   localparam int DEF_MAX_SMALL = 256;
   localparam int DEF_MAX_LARGE = 1024;
   localparam int DEF_MAX_DIMS  = 3;

   // Item commands
   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // Table selects
   localparam logic [1:0] SEL_X = 2'd0;
   localparam logic [1:0] SEL_Y = 2'd1;
   localparam logic [1:0] SEL_Z = 2'd2;

   // Register indexes
   localparam logic [3:0] CSR_NUM_DIMS   = 4'd0;
   localparam logic [3:0] CSR_MODE_ORDER = 4'd1;
   localparam logic [3:0] CSR_SMALL_X    = 4'd2;
   localparam logic [3:0] CSR_SMALL_Y    = 4'd3;
   localparam logic [3:0] CSR_SMALL_Z    = 4'd4;
   localparam logic [3:0] CSR_LARGE_X    = 4'd5;
   localparam logic [3:0] CSR_LARGE_Y    = 4'd6;
   localparam logic [3:0] CSR_LARGE_Z    = 4'd7;

   // Q8.24 rounding and magnitude limits
   localparam logic [31:0] ROUND_HALF = 32'h0080_0000;
   localparam logic [31:0] MAG_MAX    = 32'hFFFF_FFFF;
   localparam logic [31:0] POS_LIMIT  = 32'h007F_FFFF;
   localparam logic [31:0] NEG_LIMIT  = 32'h0080_0000;
   localparam logic [23:0] OUT_MAX    = 24'h7F_FFFF;
   localparam logic [23:0] OUT_MIN    = 24'h80_0000;

   // Magnitude of one sample part while it is scaled
   typedef struct packed {
      logic [31:0] mag;
      logic        over;
   } mag_type;

   // Per-dimension values derived from the size registers
   typedef struct packed {
      logic [10:0] grid;   // effective fine size
      logic [8:0]  n;      // effective retained count
      logic [7:0]  neg;    // negative modes
      logic [8:0]  nn;     // non-negative modes
      logic [10:0] lmn;    // first fine position of the negative range
   } dim_cfg_type;

   // Result of mapping one coordinate
   typedef struct packed {
      logic       keep;
      logic [7:0] idx;
      logic [8:0] pos;
   } map_type;

   // Saturated output part
   typedef struct packed {
      logic [23:0] val;
      logic        clip;
   } sat_type;

   function automatic dim_cfg_type derive_dim(logic [8:0] small_n, logic [10:0] large_n,
                                              int max_small, int max_large);
      dim_cfg_type r;
      logic [8:0]  n1;
      r.grid = (32'(large_n) > max_large) ? 11'(max_large) : large_n;
      n1     = (32'(small_n) > max_small) ? 9'(max_small) : small_n;
      r.n    = ({2'b00, n1} > r.grid) ? r.grid[8:0] : n1;
      r.neg  = r.n[8:1];
      r.nn   = r.n - {1'b0, r.neg};
      r.lmn  = r.grid - {3'b000, r.neg};
      return r;
   endfunction

   function automatic map_type map_dim(logic [9:0] c, dim_cfg_type d, logic fft_order);
      map_type    r;
      logic [10:0] c11;
      logic       low;
      logic       high;
      logic [7:0] i;
      c11   = {1'b0, c};
      low   = c11 < {2'b00, d.nn};
      high  = (c11 < d.grid) && (c11 >= d.lmn);
      i     = 8'(c11 - d.lmn);
      r.keep = low | high;
      // negative range reads the table mirrored
      r.idx = low ? c[7:0] : 8'(d.neg - i);
      if (fft_order) begin
         r.pos = low ? {1'b0, c[7:0]} : 9'(d.nn + {1'b0, i});
      end else begin
         r.pos = low ? 9'({1'b0, d.neg} + {1'b0, c[7:0]}) : {1'b0, i};
      end
      return r;
   endfunction

   function automatic sat_type saturate(mag_type m, logic neg);
      sat_type r;
      if (neg) begin
         r.clip = m.over | (m.mag > NEG_LIMIT);
         r.val  = r.clip ? OUT_MIN : 24'(24'd0 - m.mag[23:0]);
      end else begin
         r.clip = m.over | (m.mag > POS_LIMIT);
         r.val  = r.clip ? OUT_MAX : m.mag[23:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/nmtc_table.sv @@
// Correction factor table: one write port, one registered read port.
module nmtc_table import nmtc_pkg::*; #(
   parameter int DEPTH = DEF_MAX_SMALL / 2 + 1,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/nmtc_scale.sv @@
// One scaling stage: both sample parts times one Q8.24 factor, rounded, saturated.
module nmtc_scale import nmtc_pkg::*; (
   input  logic        clock,
   input  logic        en,
   input  logic        use_dim,
   input  logic [31:0] fac,
   input  mag_type     re_src,
   input  mag_type     im_src,
   output mag_type     re_res,
   output mag_type     im_res
);

   mag_type re_in, im_in;
   mag_type re_ff, im_ff;

   function automatic mag_type mul_round(mag_type m, logic [31:0] f);
      logic [63:0] prod;
      logic [39:0] q;
      mag_type     r;
      prod   = {32'd0, m.mag} * {32'd0, f} + {32'd0, ROUND_HALF};
      q      = prod[63:24];
      r.over = m.over | (|q[39:32]);
      r.mag  = (|q[39:32]) ? MAG_MAX : q[31:0];
      return r;
   endfunction

   // unused dimension passes the magnitude through
   always_comb begin
      re_in = use_dim ? mul_round(re_src, fac) : re_src;
      im_in = use_dim ? mul_round(im_src, fac) : im_src;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         re_ff <= re_in;
         im_ff <= im_in;
      end
   end

   assign re_res = re_ff;
   assign im_res = im_ff;

endmodule

@@ rtl/nufft_mode_truncate_correct_top.sv @@
// Top level: NUFFT mode truncation with per-dimension deconvolution correction.
//
// Usage:
//  - req_* carries one item per accepted cycle (req_valid high, req_stall low).
//    cmd load writes one correction table entry; cmd sample presents one
//    fine grid sample with its coordinates.
//  - rsp_* gives one item per kept sample, accepted when rsp_valid is high and
//    rsp_stall is low. Load items and dropped samples give nothing.
//  - csr_* writes the size and order registers; csr_ready is always high.
//    Write only while no items are in flight.
//  - A kept sample reaches rsp_* through the six-stage pipeline (input, map
//    and table read, scale x, scale y, scale z, saturate), which takes one
//    item per cycle while rsp_stall does not hold it back.
//  - Stall: each stage takes a new item whenever it or the stage below is free,
//    so bubbles are squeezed out; req_stall rises only with all six stages full
//    and rsp_stall high.
//  - Reset empties the pipeline and restores the registers to their reset
//    values. Table contents are kept and are undefined until loaded.
module nufft_mode_truncate_correct_top import nmtc_pkg::*; #(
   parameter int MAX_SMALL = DEF_MAX_SMALL,
   parameter int MAX_LARGE = DEF_MAX_LARGE,
   parameter int MAX_DIMS  = DEF_MAX_DIMS
) (
   input  logic               clock,
   input  logic               reset,
   // input items
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic [1:0]         req_table_sel,
   input  logic [7:0]         req_table_index,
   input  logic [31:0]        req_table_value,
   input  logic [9:0]         req_coord_x,
   input  logic [9:0]         req_coord_y,
   input  logic [9:0]         req_coord_z,
   input  logic signed [23:0] req_sample_re,
   input  logic signed [23:0] req_sample_im,
   // result items
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [23:0]        rsp_mode_index,
   output logic signed [23:0] rsp_mode_re,
   output logic signed [23:0] rsp_mode_im,
   output logic               rsp_clipped,
   // register writes
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_index,
   input  logic [10:0]        csr_data
);

   localparam int TABLE_DEPTH = MAX_SMALL / 2 + 1;
   localparam int TAW         = $clog2(TABLE_DEPTH);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [1:0]  cfg_num_dims_ff;
   logic        cfg_mode_order_ff;
   logic [8:0]  cfg_small_x_ff, cfg_small_y_ff, cfg_small_z_ff;
   logic [10:0] cfg_large_x_ff, cfg_large_y_ff, cfg_large_z_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_num_dims_ff   <= 2'd1;
         cfg_mode_order_ff <= 1'b0;
         cfg_small_x_ff    <= 9'd256;
         cfg_small_y_ff    <= 9'd256;
         cfg_small_z_ff    <= 9'd256;
         cfg_large_x_ff    <= 11'd1024;
         cfg_large_y_ff    <= 11'd1024;
         cfg_large_z_ff    <= 11'd1024;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NUM_DIMS:   cfg_num_dims_ff   <= csr_data[1:0];
            CSR_MODE_ORDER: cfg_mode_order_ff <= csr_data[0];
            CSR_SMALL_X:    cfg_small_x_ff    <= csr_data[8:0];
            CSR_SMALL_Y:    cfg_small_y_ff    <= csr_data[8:0];
            CSR_SMALL_Z:    cfg_small_z_ff    <= csr_data[8:0];
            CSR_LARGE_X:    cfg_large_x_ff    <= csr_data;
            CSR_LARGE_Y:    cfg_large_y_ff    <= csr_data;
            CSR_LARGE_Z:    cfg_large_z_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // Derived sizes, registered. Items read them from stage 1 on.
   dim_cfg_type dx_ff, dy_ff, dz_ff;
   logic        use_y_ff, use_z_ff;
   logic [1:0]  nd_lo;
   logic [1:0]  nd_in;

   always_comb begin
      nd_lo = (cfg_num_dims_ff == 2'd0) ? 2'd1 : cfg_num_dims_ff;
      nd_in = (32'(nd_lo) > MAX_DIMS) ? 2'(MAX_DIMS) : nd_lo;
   end

   always_ff @(posedge clock) begin
      dx_ff    <= derive_dim(cfg_small_x_ff, cfg_large_x_ff, MAX_SMALL, MAX_LARGE);
      dy_ff    <= derive_dim(cfg_small_y_ff, cfg_large_y_ff, MAX_SMALL, MAX_LARGE);
      dz_ff    <= derive_dim(cfg_small_z_ff, cfg_large_z_ff, MAX_SMALL, MAX_LARGE);
      use_y_ff <= nd_in >= 2'd2;
      use_z_ff <= nd_in == 2'd3;
   end

   // ---------------------------------------------------------------------
   // Pipeline control: valid per stage, stage loads when it or the next
   // stage is free
   // ---------------------------------------------------------------------
   logic [6:1] vld_ff;
   logic [6:1] vld_in;
   logic [6:1] rdy;

   always_comb begin
      rdy[6] = !vld_ff[6] || !rsp_stall;
      for (int k = 5; k >= 1; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   assign req_stall = !rdy[1];

   // ---------------------------------------------------------------------
   // Stage 1: input register
   // ---------------------------------------------------------------------
   logic               s1_cmd_ff;
   logic [1:0]         s1_sel_ff;
   logic [7:0]         s1_tidx_ff;
   logic [31:0]        s1_tval_ff;
   logic [9:0]         s1_cx_ff, s1_cy_ff, s1_cz_ff;
   logic [23:0]        s1_re_ff, s1_im_ff;

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s1_cmd_ff  <= req_cmd;
         s1_sel_ff  <= req_table_sel;
         s1_tidx_ff <= req_table_index;
         s1_tval_ff <= req_table_value;
         s1_cx_ff   <= req_coord_x;
         s1_cy_ff   <= req_coord_y;
         s1_cz_ff   <= req_coord_z;
         s1_re_ff   <= req_sample_re;
         s1_im_ff   <= req_sample_im;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1 -> 2: coordinate mapping, table write or read, sign/magnitude
   // ---------------------------------------------------------------------
   map_type     map_x, map_y, map_z;
   logic        keep_in;
   logic        is_sample;
   logic        wr_ok;
   logic [31:0] tidx32, ix32, iy32, iz32;
   logic [8:0]  s2_pos_y_in, s2_pos_z_in;
   logic [23:0] s2_mag_re_in, s2_mag_im_in;

   always_comb begin
      map_x     = map_dim(s1_cx_ff, dx_ff, cfg_mode_order_ff);
      map_y     = map_dim(s1_cy_ff, dy_ff, cfg_mode_order_ff);
      map_z     = map_dim(s1_cz_ff, dz_ff, cfg_mode_order_ff);
      keep_in   = map_x.keep && (!use_y_ff || map_y.keep) && (!use_z_ff || map_z.keep);
      is_sample = s1_cmd_ff == CMD_SAMPLE;
      tidx32    = 32'(s1_tidx_ff);
      ix32      = 32'(map_x.idx);
      iy32      = 32'(map_y.idx);
      iz32      = 32'(map_z.idx);
      // out-of-range index and select 3 are dropped
      wr_ok     = vld_ff[1] && !is_sample && (tidx32 < TABLE_DEPTH) && rdy[2];
      s2_pos_y_in  = use_y_ff ? map_y.pos : 9'd0;
      s2_pos_z_in  = use_z_ff ? map_z.pos : 9'd0;
      s2_mag_re_in = s1_re_ff[23] ? 24'(24'd0 - s1_re_ff) : s1_re_ff;
      s2_mag_im_in = s1_im_ff[23] ? 24'(24'd0 - s1_im_ff) : s1_im_ff;
   end

   logic [31:0] fac_x, fac_y, fac_z;

   nmtc_table #(.DEPTH(TABLE_DEPTH), .AW(TAW)) u_table_x (
      .clock   (clock),
      .wr_en   (wr_ok && (s1_sel_ff == SEL_X)),
      .wr_addr (tidx32[TAW-1:0]),
      .wr_data (s1_tval_ff),
      .rd_en   (rdy[2]),
      .rd_addr (ix32[TAW-1:0]),
      .rd_data (fac_x)
   );

   nmtc_table #(.DEPTH(TABLE_DEPTH), .AW(TAW)) u_table_y (
      .clock   (clock),
      .wr_en   (wr_ok && (s1_sel_ff == SEL_Y)),
      .wr_addr (tidx32[TAW-1:0]),
      .wr_data (s1_tval_ff),
      .rd_en   (rdy[2]),
      .rd_addr (iy32[TAW-1:0]),
      .rd_data (fac_y)
   );

   nmtc_table #(.DEPTH(TABLE_DEPTH), .AW(TAW)) u_table_z (
      .clock   (clock),
      .wr_en   (wr_ok && (s1_sel_ff == SEL_Z)),
      .wr_addr (tidx32[TAW-1:0]),
      .wr_data (s1_tval_ff),
      .rd_en   (rdy[2]),
      .rd_addr (iz32[TAW-1:0]),
      .rd_data (fac_z)
   );

   // Stage 2 payload (factors sit in the table read registers)
   logic [8:0]  s2_pos_x_ff, s2_pos_y_ff, s2_pos_z_ff;
   logic        s2_neg_re_ff, s2_neg_im_ff;
   logic [23:0] s2_mag_re_ff, s2_mag_im_ff;

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         s2_pos_x_ff  <= map_x.pos;
         s2_pos_y_ff  <= s2_pos_y_in;
         s2_pos_z_ff  <= s2_pos_z_in;
         s2_neg_re_ff <= s1_re_ff[23];
         s2_neg_im_ff <= s1_im_ff[23];
         s2_mag_re_ff <= s2_mag_re_in;
         s2_mag_im_ff <= s2_mag_im_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2 -> 3: scale by x factor, inner index term
   // ---------------------------------------------------------------------
   mag_type     s2_re, s2_im;
   mag_type     s3_re, s3_im, s4_re, s4_im, s5_re, s5_im;
   logic [18:0] s3_inner_in;

   always_comb begin
      s2_re.mag   = {8'd0, s2_mag_re_ff};
      s2_re.over  = 1'b0;
      s2_im.mag   = {8'd0, s2_mag_im_ff};
      s2_im.over  = 1'b0;
      // z position is zero unless z is in use, so the y size only matters in 3D
      s3_inner_in = 19'(s2_pos_y_ff) + 19'(dy_ff.n) * 19'(s2_pos_z_ff);
   end

   nmtc_scale u_scale_x (
      .clock   (clock),
      .en      (rdy[3]),
      .use_dim (1'b1),
      .fac     (fac_x),
      .re_src  (s2_re),
      .im_src  (s2_im),
      .re_res  (s3_re),
      .im_res  (s3_im)
   );

   logic [8:0]  s3_pos_x_ff;
   logic [18:0] s3_inner_ff;
   logic [31:0] s3_fac_y_ff, s3_fac_z_ff;
   logic        s3_neg_re_ff, s3_neg_im_ff;

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         s3_pos_x_ff  <= s2_pos_x_ff;
         s3_inner_ff  <= s3_inner_in;
         s3_fac_y_ff  <= fac_y;
         s3_fac_z_ff  <= fac_z;
         s3_neg_re_ff <= s2_neg_re_ff;
         s3_neg_im_ff <= s2_neg_im_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3 -> 4: scale by y factor, full linear index
   // ---------------------------------------------------------------------
   logic [27:0] s4_lin_in;

   assign s4_lin_in = 28'(s3_pos_x_ff) + 28'(dx_ff.n) * 28'(s3_inner_ff);

   nmtc_scale u_scale_y (
      .clock   (clock),
      .en      (rdy[4]),
      .use_dim (use_y_ff),
      .fac     (s3_fac_y_ff),
      .re_src  (s3_re),
      .im_src  (s3_im),
      .re_res  (s4_re),
      .im_res  (s4_im)
   );

   logic [23:0] s4_lin_ff;
   logic [31:0] s4_fac_z_ff;
   logic        s4_neg_re_ff, s4_neg_im_ff;

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         s4_lin_ff    <= s4_lin_in[23:0];
         s4_fac_z_ff  <= s3_fac_z_ff;
         s4_neg_re_ff <= s3_neg_re_ff;
         s4_neg_im_ff <= s3_neg_im_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4 -> 5: scale by z factor
   // ---------------------------------------------------------------------
   nmtc_scale u_scale_z (
      .clock   (clock),
      .en      (rdy[5]),
      .use_dim (use_z_ff),
      .fac     (s4_fac_z_ff),
      .re_src  (s4_re),
      .im_src  (s4_im),
      .re_res  (s5_re),
      .im_res  (s5_im)
   );

   logic [23:0] s5_lin_ff;
   logic        s5_neg_re_ff, s5_neg_im_ff;

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         s5_lin_ff    <= s4_lin_ff;
         s5_neg_re_ff <= s4_neg_re_ff;
         s5_neg_im_ff <= s4_neg_im_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 5 -> 6: restore sign, saturate to 24 bits; output register
   // ---------------------------------------------------------------------
   sat_type     sat_re, sat_im;
   logic [23:0] s6_index_ff;
   logic [23:0] s6_re_ff, s6_im_ff;
   logic        s6_clip_ff;

   always_comb begin
      sat_re = saturate(s5_re, s5_neg_re_ff);
      sat_im = saturate(s5_im, s5_neg_im_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy[6]) begin
         s6_index_ff <= s5_lin_ff;
         s6_re_ff    <= sat_re.val;
         s6_im_ff    <= sat_im.val;
         s6_clip_ff  <= sat_re.clip | sat_im.clip;
      end
   end

   // valid bits; loads and dropped samples leave stage 1 as bubbles
   always_comb begin
      vld_in[1] = req_valid;
      vld_in[2] = vld_ff[1] && is_sample && keep_in;
      for (int k = 3; k <= 6; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 1; k <= 6; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   assign rsp_valid      = vld_ff[6];
   assign rsp_mode_index = s6_index_ff;
   assign rsp_mode_re    = s6_re_ff;
   assign rsp_mode_im    = s6_im_ff;
   assign rsp_clipped    = s6_clip_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // a load item never turns into a result
   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[1] && (s1_cmd_ff == CMD_LOAD) && rdy[2]) |=> !vld_ff[2])
      else $error("load item entered stage 2 as valid");

   // input stalls only with every stage full and the output stalled
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ((&vld_ff) && rsp_stall))
      else $error("input stalled with a free pipeline stage");

   // a clipped result holds a limit value in at least one part
   a_clip_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |->
         ((rsp_mode_re == OUT_MAX) || (rsp_mode_re == OUT_MIN) ||
          (rsp_mode_im == OUT_MAX) || (rsp_mode_im == OUT_MIN)))
      else $error("clipped flag without a saturated part");

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the NUFFT mode truncation and correction block.
module testbench;
   import nmtc_pkg::*;

   // Limits of the instance under test (package defaults)
   localparam int MAX_SMALL   = DEF_MAX_SMALL;
   localparam int MAX_LARGE   = DEF_MAX_LARGE;
   localparam int MAX_DIMS    = DEF_MAX_DIMS;
   localparam int TABLE_DEPTH = MAX_SMALL / 2 + 1;

   // Codes the block must ignore
   localparam logic [1:0] SEL_NONE = 2'd3;
   localparam logic [3:0] CSR_NONE = 4'd15;

   // Pipeline is six stages deep; give it some margin before touching registers
   localparam int SETTLE_CYCLES = 12;
   localparam int CYCLE_LIMIT   = 400000;

   // One input item, all fields present whatever the command
   typedef struct packed {
      logic              cmd;
      logic [1:0]        sel;
      logic [7:0]        tindex;
      logic [31:0]       tvalue;
      logic [9:0]        cx;
      logic [9:0]        cy;
      logic [9:0]        cz;
      logic signed [23:0] re;
      logic signed [23:0] im;
   } grid_item_type;

   // One corrected mode as it should leave the block
   typedef struct packed {
      logic [23:0]        index;
      logic signed [23:0] re;
      logic signed [23:0] im;
      logic               clipped;
   } mode_result_type;

   logic               clock;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_stall;
   logic               req_cmd         = CMD_LOAD;
   logic [1:0]         req_table_sel   = SEL_X;
   logic [7:0]         req_table_index = '0;
   logic [31:0]        req_table_value = '0;
   logic [9:0]         req_coord_x     = '0;
   logic [9:0]         req_coord_y     = '0;
   logic [9:0]         req_coord_z     = '0;
   logic signed [23:0] req_sample_re   = '0;
   logic signed [23:0] req_sample_im   = '0;
   logic               rsp_valid;
   logic               rsp_stall       = 1'b0;
   logic [23:0]        rsp_mode_index;
   logic signed [23:0] rsp_mode_re;
   logic signed [23:0] rsp_mode_im;
   logic               rsp_clipped;
   logic               csr_valid       = 1'b0;
   logic               csr_ready;
   logic [3:0]         csr_index       = CSR_NUM_DIMS;
   logic [10:0]        csr_data        = '0;

   // Shadow copy of the block's registers and correction tables
   logic [1:0]  cfg_num_dims;
   logic        cfg_mode_order;
   logic [8:0]  cfg_small [0:2];
   logic [10:0] cfg_large [0:2];
   logic [31:0] corr_tab [0:2][0:TABLE_DEPTH-1];

   // Corrected modes still owed by the block, oldest first
   mode_result_type expected_modes [$];
   mode_result_type oldest_mode;

   int send_idle_pct = 0;   // chance per cycle that the sender holds back
   int recv_idle_pct = 0;   // chance per cycle that the receiver stalls
   int stall_hold    = 0;   // forced receiver stall, in cycles
   int mismatch_count = 0;
   int cycle_count    = 0;

   nufft_mode_truncate_correct_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_table_sel   (req_table_sel),
      .req_table_index (req_table_index),
      .req_table_value (req_table_value),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .req_sample_re   (req_sample_re),
      .req_sample_im   (req_sample_im),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_mode_index  (rsp_mode_index),
      .rsp_mode_re     (rsp_mode_re),
      .rsp_mode_im     (rsp_mode_im),
      .rsp_clipped     (rsp_clipped),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs or loses items
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Mode predictor
   // ------------------------------------------------------------------

   // Fine size after the cap
   function automatic int grid_size(input int d);
      int lg;
      lg = int'(cfg_large[d]);
      if (lg > MAX_LARGE) lg = MAX_LARGE;
      return lg;
   endfunction

   // Retained modes: min of the register, the cap and the fine size
   function automatic int retained_modes(input int d);
      int n;
      n = int'(cfg_small[d]);
      if (n > MAX_SMALL) n = MAX_SMALL;
      if (n > grid_size(d)) n = grid_size(d);
      return n;
   endfunction

   // Keep/drop one coordinate; gives the mode position and the table factor.
   // Negative range reads the table mirrored.
   function automatic bit map_coord(input int d, input int c, output int pos,
                                    output logic [31:0] fac);
      int lg, n, neg, nn, i, idx;
      lg  = grid_size(d);
      n   = retained_modes(d);
      neg = n / 2;
      nn  = n - neg;
      pos = 0;
      fac = '0;
      if (n == 0) return 0;
      if (c < nn) begin
         idx = c;
         pos = cfg_mode_order ? c : neg + c;
      end else if (c < lg && c >= lg - neg) begin
         i   = c - (lg - neg);
         idx = neg - i;
         pos = cfg_mode_order ? nn + i : i;
      end else begin
         return 0;
      end
      fac = corr_tab[d][idx];
      return 1;
   endfunction

   // Sign/magnitude scaling with round half away from zero; {clip, value}
   function automatic logic [24:0] scale_part(input logic [23:0] v,
                                              input logic [2:0][31:0] fac,
                                              input int nd);
      logic [63:0] m;
      logic [23:0] negated;
      bit          neg, over;
      int          d;
      neg  = v[23];
      m    = neg ? (64'h100_0000 - {40'd0, v}) : {40'd0, v};
      over = 0;
      for (d = 0; d < nd; d++) begin
         m = (m * {32'd0, fac[d]} + 64'h80_0000) >> 24;
         if (m > 64'hFFFF_FFFF) begin
            m    = 64'hFFFF_FFFF;
            over = 1;
         end
      end
      if (neg) begin
         if (over || m > 64'h80_0000) return {1'b1, OUT_MIN};
         negated = 24'h0 - m[23:0];
         return {1'b0, negated};
      end
      if (over || m > 64'h7F_FFFF) return {1'b1, OUT_MAX};
      return {1'b0, m[23:0]};
   endfunction

   // Expected corrected mode for one sample; returns 0 if it is dropped
   function automatic bit predict_mode(input grid_item_type it, output mode_result_type r);
      logic [2:0][9:0]  crd;
      logic [2:0][31:0] fac;
      logic [24:0]      part_re, part_im;
      logic [31:0]      f;
      int               pos [0:2];
      int               sz [0:2];
      int               nd, d, p, lin;
      r   = '0;
      crd = {it.cz, it.cy, it.cx};
      fac = '0;
      nd  = (cfg_num_dims == 2'd0) ? 1 : int'(cfg_num_dims);
      if (nd > MAX_DIMS) nd = MAX_DIMS;
      for (d = 0; d < 3; d++) begin
         pos[d] = 0;
         sz[d]  = 1;
      end
      for (d = 0; d < nd; d++) begin
         if (!map_coord(d, int'(crd[d]), p, f)) return 0;
         pos[d] = p;
         fac[d] = f;
         sz[d]  = retained_modes(d);
      end
      lin       = pos[0] + sz[0] * (pos[1] + sz[1] * pos[2]);
      part_re   = scale_part(it.re, fac, nd);
      part_im   = scale_part(it.im, fac, nd);
      r.index   = lin[23:0];
      r.re      = part_re[23:0];
      r.im      = part_im[23:0];
      r.clipped = part_re[24] | part_im[24];
      return 1;
   endfunction

   // Fold one accepted item into the shadow state and the expected queue
   task automatic apply_item(input grid_item_type it);
      mode_result_type r;
      if (it.cmd == CMD_LOAD) begin
         if (it.sel != SEL_NONE && it.tindex < TABLE_DEPTH)
            corr_tab[it.sel][it.tindex] = it.tvalue;
      end else if (predict_mode(it, r)) begin
         expected_modes.push_back(r);
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Mostly near 1.0 in Q8.24, with the extremes mixed in
   function automatic logic [31:0] rand_factor();
      case ($urandom_range(9))
         0: return 32'hFFFF_FFFF;
         1: return 32'h0000_0000;
         2: return 32'h0100_0000;
         3, 4: return $urandom;
         default: return $urandom_range(32'h0140_0000, 32'h00C0_0000);
      endcase
   endfunction

   function automatic logic [23:0] rand_part();
      case ($urandom_range(9))
         0: return OUT_MIN;
         1: return OUT_MAX;
         2: return 24'd0;
         3: return 24'($urandom_range(32)) - 24'd16;
         default: return 24'($urandom);
      endcase
   endfunction

   // Coordinate biased toward the kept ranges; the rest hits edges or anywhere
   function automatic logic [9:0] pick_coord(input int d);
      int n, lg, neg, nn, r;
      n  = retained_modes(d);
      lg = grid_size(d);
      if (n == 0 || $urandom_range(99) < 25) return 10'($urandom_range(1023));
      neg = n / 2;
      nn  = n - neg;
      if ($urandom_range(99) < 8) begin
         case ($urandom_range(2))
            0: return 10'(nn);
            1: return 10'(lg - neg - 1);
            default: return 10'(lg);
         endcase
      end
      r = $urandom_range(n - 1);
      if (r < nn) return 10'(r);
      return 10'(lg - neg + (r - nn));
   endfunction

   function automatic grid_item_type random_item();
      grid_item_type it;
      it.cmd    = ($urandom_range(99) < 15) ? CMD_LOAD : CMD_SAMPLE;
      it.sel    = 2'($urandom_range(3));
      it.tindex = ($urandom_range(99) < 90) ? 8'($urandom_range(TABLE_DEPTH - 1))
                                             : 8'($urandom_range(255));
      it.tvalue = rand_factor();
      it.cx     = pick_coord(0);
      it.cy     = pick_coord(1);
      it.cz     = pick_coord(2);
      it.re     = rand_part();
      it.im     = rand_part();
      return it;
   endfunction

   function automatic grid_item_type load_item(input logic [1:0] sel, input logic [7:0] idx,
                                               input logic [31:0] val);
      grid_item_type it;
      it        = random_item();
      it.cmd    = CMD_LOAD;
      it.sel    = sel;
      it.tindex = idx;
      it.tvalue = val;
      return it;
   endfunction

   function automatic grid_item_type sample_item(input logic [9:0] cx, input logic [23:0] re,
                                                 input logic [23:0] im);
      grid_item_type it;
      it     = random_item();
      it.cmd = CMD_SAMPLE;
      it.cx  = cx;
      it.re  = re;
      it.im  = im;
      return it;
   endfunction

   // Offer one item after an optional random gap; returns once it is taken.
   // Valid stays high into the next call, so back-to-back items never toggle it.
   task automatic send_item(input grid_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_cmd         <= it.cmd;
      req_table_sel   <= it.sel;
      req_table_index <= it.tindex;
      req_table_value <= it.tvalue;
      req_coord_x     <= it.cx;
      req_coord_y     <= it.cy;
      req_coord_z     <= it.cz;
      req_sample_re   <= it.re;
      req_sample_im   <= it.im;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_item(it);
   endtask

   // Stop offering, let every owed mode arrive, then let loads and dropped
   // samples clear the pipeline too
   task automatic settle_pipeline();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_modes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [3:0] idx, input logic [10:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_NUM_DIMS:   cfg_num_dims   = data[1:0];
         CSR_MODE_ORDER: cfg_mode_order = data[0];
         CSR_SMALL_X:    cfg_small[0]   = data[8:0];
         CSR_SMALL_Y:    cfg_small[1]   = data[8:0];
         CSR_SMALL_Z:    cfg_small[2]   = data[8:0];
         CSR_LARGE_X:    cfg_large[0]   = data;
         CSR_LARGE_Y:    cfg_large[1]   = data;
         CSR_LARGE_Z:    cfg_large[2]   = data;
         default: ;
      endcase
   endtask

   // Rewrites every register; only called with the block drained
   task automatic configure(input int nd, input int order, input int sx, input int sy,
                            input int sz, input int lx, input int ly, input int lz);
      settle_pipeline();
      write_reg(CSR_NUM_DIMS, 11'(nd));
      write_reg(CSR_MODE_ORDER, 11'(order));
      write_reg(CSR_SMALL_X, 11'(sx));
      write_reg(CSR_SMALL_Y, 11'(sy));
      write_reg(CSR_SMALL_Z, 11'(sz));
      write_reg(CSR_LARGE_X, 11'(lx));
      write_reg(CSR_LARGE_Y, 11'(ly));
      write_reg(CSR_LARGE_Z, 11'(lz));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly small grids so many samples land in the kept ranges.
   // Upper data bits above the width of the count, order and small-size registers are junk on purpose.
   task automatic random_config();
      int lg [0:2];
      int sm [0:2];
      int d;
      for (d = 0; d < 3; d++) begin
         case ($urandom_range(9))
            0: lg[d] = 1024;
            1: lg[d] = $urandom_range(2047);
            2: lg[d] = $urandom_range(1024, 1);
            default: lg[d] = $urandom_range(64, 1);
         endcase
         case ($urandom_range(9))
            0: sm[d] = 256;
            1: sm[d] = $urandom_range(511);
            default: sm[d] = (lg[d] == 0) ? 0 : $urandom_range((lg[d] > 256) ? 256 : lg[d], 1);
         endcase
         sm[d] = sm[d] + 512 * $urandom_range(3);
      end
      configure($urandom_range(3) + 4 * $urandom_range(511),
                $urandom_range(1) + 2 * $urandom_range(1023),
                sm[0], sm[1], sm[2], lg[0], lg[1], lg[2]);
   endtask

   // ------------------------------------------------------------------
   // Receiver and result checking
   // ------------------------------------------------------------------

   // Random stall, or a forced stretch when stall_hold is loaded
   always @(negedge clock) begin
      if (stall_hold > 0) begin
         rsp_stall <= 1'b1;
         stall_hold = stall_hold - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
   endtask

   // Every accepted result item against the oldest owed mode
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_modes.size() == 0) begin
            report_mismatch($sformatf("unexpected item index %h re %0d im %0d",
                                      rsp_mode_index, rsp_mode_re, rsp_mode_im));
         end else begin
            oldest_mode = expected_modes.pop_front();
            if (rsp_mode_index !== oldest_mode.index || rsp_mode_re !== oldest_mode.re ||
                rsp_mode_im !== oldest_mode.im || rsp_clipped !== oldest_mode.clipped)
               report_mismatch($sformatf(
                  "index %h/%h re %0d/%0d im %0d/%0d clipped %b/%b (got/exp)",
                  rsp_mode_index, oldest_mode.index, rsp_mode_re, oldest_mode.re,
                  rsp_mode_im, oldest_mode.im, rsp_clipped, oldest_mode.clipped));
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Fill every entry of all three tables so no sample reads an unloaded one
   task automatic test_table_preload();
      int sel, idx;
      for (sel = 0; sel < 3; sel++)
         for (idx = 0; idx < TABLE_DEPTH; idx++)
            send_item(load_item(2'(sel), 8'(idx), rand_factor()));
   endtask

   // Register reset values: 1D, centered, 256 of 1024 kept
   task automatic test_reset_defaults();
      send_item(sample_item(10'd0, OUT_MAX, OUT_MIN));     // mode 0
      send_item(sample_item(10'd127, OUT_MIN, OUT_MAX));   // last non-negative
      send_item(sample_item(10'd128, 24'd5, 24'd5));       // first dropped
      send_item(sample_item(10'd895, 24'd7, 24'd7));       // last dropped
      send_item(sample_item(10'd896, 24'd0, 24'd1));       // most negative mode
      send_item(sample_item(10'd1023, 24'h123456, 24'hFEDCBA));
   endtask

   // Select 3 and indexes past the table depth must not write anything
   task automatic test_ignored_loads();
      send_item(load_item(SEL_NONE, 8'd5, 32'h0000_0001));
      send_item(load_item(SEL_X, 8'd129, 32'h0000_0002));
      send_item(load_item(SEL_X, 8'd255, 32'hFFFF_FFFF));
      send_item(sample_item(10'd5, 24'h400000, 24'hC00000));
      send_item(load_item(SEL_X, 8'd128, 32'h0100_0000));
      send_item(sample_item(10'd896, 24'h2AAAAA, 24'hD55555));
   endtask

   // Saturation both ways, exact unity, zero factor, rounding of halves
   task automatic test_saturation();
      send_item(load_item(SEL_X, 8'd1, 32'hFFFF_FFFF));
      send_item(load_item(SEL_X, 8'd2, 32'h0100_0000));
      send_item(load_item(SEL_X, 8'd3, 32'h0000_0000));
      send_item(load_item(SEL_X, 8'd4, 32'h0080_0000));
      send_item(sample_item(10'd1, OUT_MAX, OUT_MIN));
      send_item(sample_item(10'd2, OUT_MIN, OUT_MAX));
      send_item(sample_item(10'd3, rand_part(), rand_part()));
      send_item(sample_item(10'd4, 24'd1, 24'hFFFFFF));
      send_item(sample_item(10'd4, 24'd3, 24'hFFFFFD));
   endtask

   // Corner settings of the registers, each with a short random burst
   task automatic test_config_extremes();
      configure(1, 1, 256, 256, 256, 1024, 1024, 1024);   // FFT order
      repeat (15) send_item(random_item());
      configure(3, 0, 256, 256, 256, 1024, 1024, 1024);   // full 3D
      repeat (15) send_item(random_item());
      settle_pipeline();
      write_reg(CSR_NONE, 11'h7FF);                       // no such register
      @(negedge clock);
      csr_valid <= 1'b0;
      repeat (10) send_item(random_item());
      configure(2, 1, 257, 511, 0, 2047, 1025, 0);        // caps on both sizes
      repeat (15) send_item(random_item());
      configure(0, 0, 0, 5, 5, 8, 8, 8);                  // zero dims, nothing kept
      repeat (10) send_item(random_item());
      configure(1, 0, 7, 5, 5, 0, 8, 8);                  // empty fine grid
      repeat (10) send_item(random_item());
      configure(3, 1, 1, 2, 3, 1, 5, 2);                  // tiny, small above large
      repeat (15) send_item(random_item());
   endtask

   task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                      input int settings);
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      repeat (settings) begin
         random_config();
         repeat (6) send_item(random_item());
      end
   endtask

   // Receiver blocks for a long stretch while the sender keeps pushing,
   // so the pipeline fills and the input stalls
   task automatic test_input_backpressure();
      int saved_pct;
      grid_item_type it;
      saved_pct = send_idle_pct;
      configure(1, 1, 16, 256, 256, 32, 1024, 1024);
      send_idle_pct = 0;
      stall_hold    = 150;
      repeat (40) begin
         it     = random_item();
         it.cmd = CMD_SAMPLE;
         send_item(it);
      end
      send_idle_pct = saved_pct;
   endtask

   // Sender stops until every owed mode is out, then resumes
   task automatic test_drain_pause();
      repeat (15) send_item(random_item());
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_modes.size() != 0) @(posedge clock);
      repeat (15) send_item(random_item());
   endtask

   initial begin
      int drain_wait;
      // shadow registers start at the block's reset values
      cfg_num_dims   = 2'd1;
      cfg_mode_order = 1'b0;
      for (int d = 0; d < 3; d++) begin
         cfg_small[d] = 9'd256;
         cfg_large[d] = 11'd1024;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // phase one: sender idles a little, receiver a lot
      send_idle_pct = 11;
      recv_idle_pct = 64;
      test_table_preload();
      test_reset_defaults();
      test_ignored_loads();
      test_saturation();
      test_config_extremes();
      test_random_traffic(11, 64, 4);
      // phase two: the other way round
      test_random_traffic(64, 11, 4);
      test_input_backpressure();
      // phase three: no idling on either side
      test_random_traffic(0, 0, 4);
      test_drain_pause();

      // drain, then give the pipeline time to show any stray item
      @(negedge clock);
      req_valid <= 1'b0;
      drain_wait = 0;
      while (expected_modes.size() != 0 && drain_wait < 5000) begin
         @(posedge clock);
         drain_wait++;
      end
      if (expected_modes.size() != 0)
         report_mismatch($sformatf("%0d expected items never came", expected_modes.size()));
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ nufft_mode_truncate_correct_top.f @@
rtl/nmtc_pkg.sv
rtl/nmtc_table.sv
rtl/nmtc_scale.sv
rtl/nufft_mode_truncate_correct_top.sv
tb/sv/testbench.sv
